### rtl/i2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character constants, operator tables and the microcode ROM
// of the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int PC_W            = 5;

	typedef logic [PC_W-1:0] pc_t;
	typedef logic [2:0]      op_t;
	typedef logic [7:0]      char_t;

	// characters
	localparam char_t CH_OPEN  = 8'h28; // (
	localparam char_t CH_CLOSE = 8'h29; // )
	localparam char_t CH_MUL   = 8'h2A; // *
	localparam char_t CH_PLUS  = 8'h2B; // +
	localparam char_t CH_COMMA = 8'h2C; // ,
	localparam char_t CH_MINUS = 8'h2D; // -
	localparam char_t CH_DIV   = 8'h2F; // /
	localparam char_t CH_ZERO  = 8'h30; // 0
	localparam char_t CH_NINE  = 8'h39; // 9
	localparam char_t CH_QUEST = 8'h3F; // ?
	localparam char_t CH_UPA   = 8'h41; // A
	localparam char_t CH_UPZ   = 8'h5A; // Z
	localparam char_t CH_CARET = 8'h5E; // ^
	localparam char_t CH_LOA   = 8'h61; // a
	localparam char_t CH_LOZ   = 8'h7A; // z
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_NUL   = 8'h00;

	// stacked operator codes
	localparam op_t OP_OPEN  = 3'd0;
	localparam op_t OP_PLUS  = 3'd1;
	localparam op_t OP_MINUS = 3'd2;
	localparam op_t OP_MUL   = 3'd3;
	localparam op_t OP_DIV   = 3'd4;
	localparam op_t OP_POW   = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_UNK  = 2'd2;

	// microcode addresses; consecutive steps fall through
	localparam pc_t U_FETCH    = 5'd0;
	localparam pc_t U_OPND     = 5'd1;
	localparam pc_t U_DLM      = 5'd2;
	localparam pc_t U_OPN_CR   = 5'd3;
	localparam pc_t U_OPN_PUSH = 5'd4;
	localparam pc_t U_CLS_CR   = 5'd5;
	localparam pc_t U_CLS_TEST = 5'd6;
	localparam pc_t U_CLS_TOP  = 5'd7;
	localparam pc_t U_CLS_SP   = 5'd8;
	localparam pc_t U_CLS_DROP = 5'd9;
	localparam pc_t U_OPR_CR   = 5'd10;
	localparam pc_t U_OPR_Z    = 5'd11;
	localparam pc_t U_OPR_ZSP  = 5'd12;
	localparam pc_t U_OPR_TEST = 5'd13;
	localparam pc_t U_OPR_TOP  = 5'd14;
	localparam pc_t U_OPR_SP   = 5'd15;
	localparam pc_t U_OPR_PUSH = 5'd16;
	localparam pc_t U_UNK_CR   = 5'd17;
	localparam pc_t U_UNK_ERR  = 5'd18;
	localparam pc_t U_TAIL     = 5'd19;
	localparam pc_t U_FL_CR    = 5'd20;
	localparam pc_t U_FL_TEST  = 5'd21;
	localparam pc_t U_FL_TOP   = 5'd22;
	localparam pc_t U_FL_SP    = 5'd23;
	localparam pc_t U_END      = 5'd24;

	typedef enum logic [3:0] {
		C_NEVER      = 4'd0,
		C_TRUE       = 4'd1,
		C_RUN        = 4'd2,
		C_MINUS_PREV = 4'd3,
		C_NOT_LAST   = 4'd4,
		C_EMPTY      = 4'd5,
		C_NOT_EMPTY  = 4'd6,
		C_STOP_CLOSE = 4'd7,
		C_STOP_OP    = 4'd8
	} cond_t;

	typedef enum logic [2:0] {
		E_NONE  = 3'd0,
		E_CHAR  = 3'd1,
		E_SPACE = 3'd2,
		E_ZERO  = 3'd3,
		E_TOP   = 3'd4
	} emit_t;

	typedef struct packed {
		cond_t guard;
		emit_t emit;
		logic  run_set;
		logic  run_clr;
		logic  prev_set;
		logic  prev_clr;
		logic  push_open;
		logic  push_op;
		logic  pop;
		logic  err_unk;
		logic  fin;
		cond_t jump;
		pc_t   target;
	} cw_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
		op_t  code;
	} stk_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		op_t  top;
	} stk_sts_t;

	function automatic op_t op_code(input char_t ch);
		op_t c;
		case (ch)
			CH_PLUS:  c = OP_PLUS;
			CH_MINUS: c = OP_MINUS;
			CH_MUL:   c = OP_MUL;
			CH_DIV:   c = OP_DIV;
			CH_CARET: c = OP_POW;
			default:  c = OP_OPEN;
		endcase
		return c;
	endfunction

	// '(' ranks below every operator, so it stops a pop loop
	function automatic logic [1:0] op_prec(input op_t c);
		logic [1:0] p;
		case (c)
			OP_PLUS, OP_MINUS: p = 2'd1;
			OP_MUL, OP_DIV:    p = 2'd2;
			OP_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic char_t code_char(input op_t c);
		char_t ch;
		case (c)
			OP_OPEN:  ch = CH_OPEN;
			OP_PLUS:  ch = CH_PLUS;
			OP_MINUS: ch = CH_MINUS;
			OP_MUL:   ch = CH_MUL;
			OP_DIV:   ch = CH_DIV;
			OP_POW:   ch = CH_CARET;
			default:  ch = CH_QUEST;
		endcase
		return ch;
	endfunction

	function automatic pc_t class_entry(input char_t ch);
		pc_t e;
		if ((ch >= CH_UPA && ch <= CH_UPZ) || (ch >= CH_LOA && ch <= CH_LOZ) ||
		    (ch >= CH_ZERO && ch <= CH_NINE)) begin
			e = U_OPND;
		end else begin
			case (ch)
				CH_SPACE, CH_COMMA:                       e = U_DLM;
				CH_OPEN:                                  e = U_OPN_CR;
				CH_CLOSE:                                 e = U_CLS_CR;
				CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_CARET: e = U_OPR_CR;
				default:                                  e = U_UNK_CR;
			endcase
		end
		return e;
	endfunction

	// close an open operand run with one space
	function automatic cw_t cw_close_run();
		cw_t w;
		w         = '0;
		w.guard   = C_RUN;
		w.emit    = E_SPACE;
		w.run_clr = 1'b1;
		w.jump    = C_NEVER;
		return w;
	endfunction

	function automatic cw_t ucode(input pc_t pc);
		cw_t w;
		w        = '0;
		w.guard  = C_NEVER;
		w.emit   = E_NONE;
		w.jump   = C_NEVER;
		w.target = U_FETCH;
		unique case (pc)
			U_FETCH: begin
			end
			U_OPND: begin
				w.guard = C_TRUE; w.emit = E_CHAR; w.run_set = 1'b1; w.prev_clr = 1'b1;
				w.jump = C_TRUE; w.target = U_TAIL;
			end
			U_DLM: begin
				w = cw_close_run(); w.jump = C_TRUE; w.target = U_TAIL;
			end
			U_OPN_CR: w = cw_close_run();
			U_OPN_PUSH: begin
				w.guard = C_TRUE; w.push_open = 1'b1; w.prev_set = 1'b1;
				w.jump = C_TRUE; w.target = U_TAIL;
			end
			U_CLS_CR: w = cw_close_run();
			U_CLS_TEST: begin
				w.guard = C_TRUE; w.prev_clr = 1'b1;
				w.jump = C_STOP_CLOSE; w.target = U_CLS_DROP;
			end
			U_CLS_TOP: begin
				w.guard = C_TRUE; w.emit = E_TOP;
			end
			U_CLS_SP: begin
				w.guard = C_TRUE; w.emit = E_SPACE; w.pop = 1'b1;
				w.jump = C_TRUE; w.target = U_CLS_TEST;
			end
			U_CLS_DROP: begin
				w.guard = C_NOT_EMPTY; w.pop = 1'b1;
				w.jump = C_TRUE; w.target = U_TAIL;
			end
			U_OPR_CR: w = cw_close_run();
			U_OPR_Z: begin
				w.guard = C_MINUS_PREV; w.emit = E_ZERO;
			end
			U_OPR_ZSP: begin
				w.guard = C_MINUS_PREV; w.emit = E_SPACE;
			end
			U_OPR_TEST: begin
				w.jump = C_STOP_OP; w.target = U_OPR_PUSH;
			end
			U_OPR_TOP: begin
				w.guard = C_TRUE; w.emit = E_TOP;
			end
			U_OPR_SP: begin
				w.guard = C_TRUE; w.emit = E_SPACE; w.pop = 1'b1;
				w.jump = C_TRUE; w.target = U_OPR_TEST;
			end
			U_OPR_PUSH: begin
				w.guard = C_TRUE; w.push_op = 1'b1; w.prev_clr = 1'b1;
				w.jump = C_TRUE; w.target = U_TAIL;
			end
			U_UNK_CR: w = cw_close_run();
			U_UNK_ERR: begin
				w.guard = C_TRUE; w.err_unk = 1'b1; w.prev_clr = 1'b1;
			end
			U_TAIL: begin
				w.jump = C_NOT_LAST; w.target = U_END;
			end
			U_FL_CR: w = cw_close_run();
			U_FL_TEST: begin
				w.jump = C_EMPTY; w.target = U_END;
			end
			U_FL_TOP: begin
				w.guard = C_TRUE; w.emit = E_TOP;
			end
			U_FL_SP: begin
				w.guard = C_TRUE; w.emit = E_SPACE; w.pop = 1'b1;
				w.jump = C_TRUE; w.target = U_FL_TEST;
			end
			U_END: begin
				w.guard = C_TRUE; w.fin = 1'b1;
			end
			default: begin
				w.guard = C_TRUE; w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/i2p_op_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_op_stack
// Bounded operator stack: entry memory, fill count and a registered top.
// ----------------------------------------------------------------------------
module i2p_op_stack #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2p_pkg::stk_ctl_t ctl,
	output i2p_pkg::stk_sts_t sts
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	i2p_pkg::op_t mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m2;
	i2p_pkg::op_t  top_q;
	logic          full;
	logic          wr_en;

	assign full   = (cnt_q == CW'(STACK_DEPTH));
	assign wr_en  = ctl.push && !full;
	assign cnt_m2 = cnt_q - CW'(2);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IW-1:0]] <= ctl.code;
		end
	end

	// top follows a push directly, a pop reads the entry below
	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_q <= ctl.code;
		end else if (ctl.pop) begin
			top_q <= mem[cnt_m2[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
		end else if (wr_en) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (ctl.pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign sts.empty = (cnt_q == '0);
	assign sts.full  = full;
	assign sts.top   = top_q;

endmodule

### rtl/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard infix to postfix converter, one ASCII character per transfer,
// run by a microcoded sequencer over an operator stack.
//
//  channel  dir  tdata       tlast     tuser
//  s_*      in   in_char     in_last   -
//  m_*      out  out_char    out_last  err_code
//
// One input transfer at a time; the sequencer runs one microcode step a cycle
// while it does not wait on the output. A character runs the steps of its class,
// popping operators as needed; a final character also flushes the stack.
// Reset (arst_n low) empties the stack and clears run, open and error flags.
// Output bytes pass through a one-byte hold and an output register; when both
// are full and m_tready is low the sequencer waits on its emitting or final step.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,   // out_last
	output logic [1:0] m_tuser    // [1:0] err_code
);

	i2p_pkg::pc_t      pc_q;
	i2p_pkg::pc_t      pc_nxt;
	i2p_pkg::char_t    ch_q;
	logic              last_q;
	logic              run_q;
	logic              prev_q;
	logic [1:0]        err_q;
	logic              pend_v_q;
	i2p_pkg::char_t    pend_q;
	logic              out_v_q;
	i2p_pkg::char_t    out_char_q;
	logic              out_last_q;
	logic [1:0]        out_err_q;

	i2p_pkg::cw_t      cw;
	i2p_pkg::stk_ctl_t stk_ctl;
	i2p_pkg::stk_sts_t stk_sts;
	i2p_pkg::op_t      in_op;
	i2p_pkg::char_t    emit_byte;
	logic              fetch;
	logic              accept;
	logic              g_ok;
	logic              j_ok;
	logic              emits;
	logic              need_slot;
	logic              slot_free;
	logic              stall;
	logic              exec;
	logic              out_load;
	logic              done_last;

	i2p_op_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (stk_ctl),
		.sts   (stk_sts)
	);

	function automatic logic cond_hit(input i2p_pkg::cond_t c, input logic run,
	                                  input logic minus_prev, input logic last,
	                                  input i2p_pkg::stk_sts_t st, input i2p_pkg::op_t op);
		logic h;
		unique case (c)
			i2p_pkg::C_NEVER:      h = 1'b0;
			i2p_pkg::C_TRUE:       h = 1'b1;
			i2p_pkg::C_RUN:        h = run;
			i2p_pkg::C_MINUS_PREV: h = minus_prev;
			i2p_pkg::C_NOT_LAST:   h = !last;
			i2p_pkg::C_EMPTY:      h = st.empty;
			i2p_pkg::C_NOT_EMPTY:  h = !st.empty;
			i2p_pkg::C_STOP_CLOSE: h = st.empty || (st.top == i2p_pkg::OP_OPEN);
			i2p_pkg::C_STOP_OP:    h = st.empty ||
			                           (i2p_pkg::op_prec(op) > i2p_pkg::op_prec(st.top));
			default:               h = 1'b0;
		endcase
		return h;
	endfunction

	assign cw        = i2p_pkg::ucode(pc_q);
	assign in_op     = i2p_pkg::op_code(ch_q);
	assign fetch     = (pc_q == i2p_pkg::U_FETCH);
	assign s_tready  = fetch;
	assign accept    = s_tvalid && fetch;
	assign slot_free = !out_v_q || m_tready;

	always_comb begin
		g_ok = cond_hit(cw.guard, run_q, prev_q && (ch_q == i2p_pkg::CH_MINUS),
		                last_q, stk_sts, in_op);
		j_ok = cond_hit(cw.jump, run_q, prev_q && (ch_q == i2p_pkg::CH_MINUS),
		                last_q, stk_sts, in_op);
		emits     = g_ok && (cw.emit != i2p_pkg::E_NONE);
		need_slot = cw.fin ? (pend_v_q || last_q) : (emits && pend_v_q);
		stall     = !fetch && need_slot && !slot_free;
		exec      = !fetch && g_ok && !stall;
		out_load  = exec && ((emits && pend_v_q) || (cw.fin && (pend_v_q || last_q)));
		done_last = exec && cw.fin && last_q;

		unique case (cw.emit)
			i2p_pkg::E_CHAR:  emit_byte = ch_q;
			i2p_pkg::E_SPACE: emit_byte = i2p_pkg::CH_SPACE;
			i2p_pkg::E_ZERO:  emit_byte = i2p_pkg::CH_ZERO;
			i2p_pkg::E_TOP:   emit_byte = i2p_pkg::code_char(stk_sts.top);
			default:          emit_byte = i2p_pkg::CH_NUL;
		endcase

		stk_ctl.push = exec && (cw.push_open || cw.push_op);
		stk_ctl.pop  = exec && cw.pop;
		stk_ctl.clr  = done_last;
		stk_ctl.code = cw.push_open ? i2p_pkg::OP_OPEN : in_op;

		if (fetch) begin
			pc_nxt = accept ? i2p_pkg::class_entry(s_tdata) : i2p_pkg::U_FETCH;
		end else if (stall) begin
			pc_nxt = pc_q;
		end else if (cw.fin) begin
			pc_nxt = i2p_pkg::U_FETCH;
		end else if (j_ok) begin
			pc_nxt = cw.target;
		end else begin
			pc_nxt = i2p_pkg::pc_t'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= i2p_pkg::U_FETCH;
			run_q    <= 1'b0;
			prev_q   <= 1'b0;
			err_q    <= i2p_pkg::ERR_NONE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			pc_q <= pc_nxt;

			if (done_last) begin
				run_q  <= 1'b0;
				prev_q <= 1'b0;
				err_q  <= i2p_pkg::ERR_NONE;
			end else if (exec) begin
				if (cw.run_set) begin
					run_q <= 1'b1;
				end else if (cw.run_clr) begin
					run_q <= 1'b0;
				end
				if (cw.prev_set) begin
					prev_q <= 1'b1;
				end else if (cw.prev_clr) begin
					prev_q <= 1'b0;
				end
				if (err_q == i2p_pkg::ERR_NONE) begin
					if (stk_ctl.push && stk_sts.full) begin
						err_q <= i2p_pkg::ERR_OVF;
					end else if (cw.err_unk) begin
						err_q <= i2p_pkg::ERR_UNK;
					end
				end
			end

			if (exec && emits) begin
				pend_v_q <= 1'b1;
			end else if (exec && cw.fin) begin
				pend_v_q <= 1'b0;
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= s_tdata;
			last_q <= s_tlast;
		end
		if (exec && emits) begin
			pend_q <= emit_byte;
		end
		if (out_load) begin
			out_char_q <= pend_v_q ? pend_q : i2p_pkg::CH_NUL;
			out_last_q <= cw.fin && last_q;
			out_err_q  <= (cw.fin && last_q) ? err_q : i2p_pkg::ERR_NONE;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

### rtl/i2p_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks for the infix to postfix converter, bound to the top.
// ----------------------------------------------------------------------------
module i2p_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
		else $error("stalled result changed");

	// one character in work at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// error code only rides on the final byte
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == 2'd0)
		else $error("error code on non-final byte");

	// the null byte is only the empty end marker
	a_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == 8'h00) |-> m_tlast)
		else $error("null byte before end");

	// s_tdata and s_tlast are part of the port view but carry no check here
	logic unused_in;
	assign unused_in = ^{s_tdata, s_tlast};

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

### tb/infix_to_postfix_converter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_test
// Self-checking bench for the infix to postfix converter. Characters go in as
// stream transfers, a local shunting-yard model predicts every postfix byte,
// and each output transfer is checked against the oldest predicted byte.
// Covers directed expressions, stack overflow, random well-formed expressions
// with noise, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_test;
	import i2p_pkg::*;

	localparam int DEPTH        = STACK_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		char_t      ch;
		logic       last;
		logic [1:0] err;
	} pf_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	// predicted output bytes, oldest first
	pf_byte_t postfix_q[$];
	int       fail_cnt = 0;

	// model state
	op_t        op_stk[DEPTH];
	int         stk_depth;
	bit         run_open;
	bit         after_open;
	logic [1:0] sticky_err;
	int         n_out;

	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	int  stall_len    = 0;
	bit  stall_tgl    = 1'b0;
	bit  stall_seen   = 1'b0;
	int  stall_left   = 0;

	char_t    expr_q[$];
	pf_byte_t got;

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---------------------------------------------------------------- model

	function automatic int rank(input op_t c);
		case (c)
			OP_PLUS, OP_MINUS: return 1;
			OP_MUL, OP_DIV:    return 2;
			OP_POW:            return 3;
			default:           return -1;
		endcase
	endfunction

	function automatic char_t op_glyph(input op_t c);
		case (c)
			OP_OPEN:  return CH_OPEN;
			OP_PLUS:  return CH_PLUS;
			OP_MINUS: return CH_MINUS;
			OP_MUL:   return CH_MUL;
			OP_DIV:   return CH_DIV;
			OP_POW:   return CH_CARET;
			default:  return CH_QUEST;
		endcase
	endfunction

	function automatic bit is_operator(input char_t c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
		       c == CH_CARET;
	endfunction

	function automatic op_t char_to_op(input char_t c);
		case (c)
			CH_PLUS:  return OP_PLUS;
			CH_MINUS: return OP_MINUS;
			CH_MUL:   return OP_MUL;
			CH_DIV:   return OP_DIV;
			default:  return OP_POW;
		endcase
	endfunction

	function automatic bit is_operand(input char_t c);
		return (c >= CH_UPA && c <= CH_UPZ) || (c >= CH_LOA && c <= CH_LOZ) ||
		       (c >= CH_ZERO && c <= CH_NINE);
	endfunction

	function automatic op_t stack_top();
		if (stk_depth == 0)
			return OP_OPEN;
		return op_stk[stk_depth-1];
	endfunction

	task automatic clear_state();
		stk_depth  = 0;
		run_open   = 1'b0;
		after_open = 1'b0;
		sticky_err = ERR_NONE;
	endtask

	task automatic put(input char_t c);
		postfix_q.push_back('{ch: c, last: 1'b0, err: ERR_NONE});
		n_out++;
	endtask

	task automatic flag(input logic [1:0] e);
		if (sticky_err == ERR_NONE)
			sticky_err = e;
	endtask

	task automatic end_run();
		if (run_open) begin
			put(CH_SPACE);
			run_open = 1'b0;
		end
	endtask

	task automatic pop_one();
		op_t t;
		t = stack_top();
		stk_depth--;
		put(op_glyph(t));
		put(CH_SPACE);
	endtask

	task automatic push_op(input op_t c);
		if (stk_depth >= DEPTH) begin
			flag(ERR_OVF);
		end else begin
			op_stk[stk_depth] = c;
			stk_depth++;
		end
	endtask

	task automatic convert_char(input char_t c, input logic l);
		op_t      oc;
		pf_byte_t tail;
		n_out = 0;
		if (is_operand(c)) begin
			put(c);
			run_open   = 1'b1;
			after_open = 1'b0;
		end else if (c == CH_SPACE || c == CH_COMMA) begin
			end_run();
		end else if (c == CH_OPEN) begin
			end_run();
			push_op(OP_OPEN);
			after_open = 1'b1;
		end else if (c == CH_CLOSE) begin
			end_run();
			while (stk_depth > 0 && stack_top() != OP_OPEN)
				pop_one();
			if (stk_depth > 0)
				stk_depth--;
			after_open = 1'b0;
		end else if (is_operator(c)) begin
			end_run();
			if (c == CH_MINUS && after_open) begin
				put(CH_ZERO);
				put(CH_SPACE);
			end
			oc = char_to_op(c);
			while (stk_depth > 0 && rank(oc) <= rank(stack_top()))
				pop_one();
			push_op(oc);
			after_open = 1'b0;
		end else begin
			end_run();
			flag(ERR_UNK);
			after_open = 1'b0;
		end
		if (l) begin
			end_run();
			while (stk_depth > 0)
				pop_one();
			if (n_out == 0)
				put(CH_NUL);
			tail      = postfix_q.pop_back();
			tail.last = 1'b1;
			tail.err  = sticky_err;
			postfix_q.push_back(tail);
			clear_state();
		end
	endtask

	// ------------------------------------------------------------- receiver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_tgl != stall_seen) begin
				stall_seen = stall_tgl;
				stall_left = stall_len;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (postfix_q.size() == 0) begin
				$error("unexpected transfer: out_char %h out_last %b err_code %0d",
				       m_tdata, m_tlast, m_tuser);
				fail_cnt++;
			end else begin
				got = postfix_q.pop_front();
				if (m_tdata !== got.ch) begin
					$error("out_char: expected %h, actual %h", got.ch, m_tdata);
					fail_cnt++;
				end
				if (m_tlast !== got.last) begin
					$error("out_last: expected %b, actual %b", got.last, m_tlast);
					fail_cnt++;
				end
				if (m_tuser !== got.err) begin
					$error("err_code: expected %0d, actual %0d", got.err, m_tuser);
					fail_cnt++;
				end
			end
		end
	end

	// --------------------------------------------------------------- sender

	task automatic send_char(input char_t c, input logic l);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		convert_char(c, l);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic sender_pause();
		s_tvalid <= 1'b0;
		while (postfix_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic char_t rand_operand();
		case ($urandom_range(0, 2))
			0:       return char_t'(CH_UPA + $urandom_range(0, 25));
			1:       return char_t'(CH_LOA + $urandom_range(0, 25));
			default: return char_t'(CH_ZERO + $urandom_range(0, 9));
		endcase
	endfunction

	function automatic char_t rand_operator();
		case ($urandom_range(0, 4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			3:       return CH_DIV;
			default: return CH_CARET;
		endcase
	endfunction

	// well-formed expression into expr_q, sometimes with one byte corrupted
	task automatic build_expr();
		int target;
		int open_cnt;
		int open_max;
		bit need_opnd;
		expr_q.delete();
		target    = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 20);
		open_max  = ($urandom_range(0, 9) == 0) ? 20 : 6;
		open_cnt  = 0;
		need_opnd = 1'b1;
		forever begin
			if (need_opnd) begin
				if ($urandom_range(0, 99) < 25 && open_cnt < open_max) begin
					expr_q.push_back(CH_OPEN);
					open_cnt++;
					if ($urandom_range(0, 99) < 30)
						expr_q.push_back(CH_MINUS);
				end else begin
					repeat ($urandom_range(1, 3))
						expr_q.push_back(rand_operand());
					need_opnd = 1'b0;
				end
			end else begin
				if (expr_q.size() >= target)
					break;
				if ($urandom_range(0, 99) < 25 && open_cnt > 0) begin
					expr_q.push_back(CH_CLOSE);
					open_cnt--;
				end else begin
					expr_q.push_back(rand_operator());
					need_opnd = 1'b1;
				end
			end
			if ($urandom_range(0, 99) < 8)
				expr_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
		end
		while (open_cnt > 0 && $urandom_range(0, 99) < 85) begin
			expr_q.push_back(CH_CLOSE);
			open_cnt--;
		end
		if ($urandom_range(0, 9) == 0)
			expr_q[$urandom_range(0, expr_q.size() - 1)] = char_t'($urandom_range(0, 255));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		send_text("a+b*c^d^e-(-9)/Z");
		send_text("0,z)");
		send_text("(A ");
		send_char(CH_QUEST, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_NUL, 1'b1);
		send_char(CH_SPACE, 1'b1);
	endtask

	task automatic test_overflow();
		repeat (DEPTH + 1)
			send_char(CH_OPEN, 1'b0);
		send_char(CH_LOZ, 1'b1);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				k = $urandom_range(1, 6);
				repeat (k)
					send_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
				sent += k;
			end else begin
				build_expr();
				for (int i = 0; i < expr_q.size(); i++)
					send_char(expr_q[i], i == expr_q.size() - 1);
				sent += expr_q.size();
			end
		end
	endtask

	task automatic test_backpressure();
		stall_len = 400;
		stall_tgl <= ~stall_tgl;
		test_random(60);
		sender_pause();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		clear_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 34;
		snk_idle_pct <= 88;
		test_directed();
		test_overflow();
		test_random(100);
		sender_pause();

		src_idle_pct = 88;
		snk_idle_pct <= 34;
		test_random(100);
		test_backpressure();

		src_idle_pct = 0;
		snk_idle_pct <= 0;
		test_random(100);
		sender_pause();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (postfix_q.size() != 0) begin
			$error("%0d expected bytes never arrived", postfix_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0) begin
			$display("** infix_to_postfix_converter_top: PASSED **");
		end else begin
			$display("** infix_to_postfix_converter_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#4_500_000;
		$display("** infix_to_postfix_converter_top: FAILED **");
		$finish;
	end

endmodule
